// ----- hw/rtl/palette_blend_lookup_defines.svh -----
// ----------------------------------------------------------------------------
// palette blend lookup assertion macros
// shared concurrent assertion forms used by the palette blend lookup rtl
// ----------------------------------------------------------------------------
`ifndef PALETTE_BLEND_LOOKUP_DEFINES_SVH
`define PALETTE_BLEND_LOOKUP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pbl_pkg.sv -----
// ----------------------------------------------------------------------------
// pbl_pkg
// shared constants, types and helpers of the palette blend lookup
// ----------------------------------------------------------------------------
`default_nettype none

package pbl_pkg;

   localparam int COLOR_W        = 8;
   localparam int INDEX_W        = 8;
   localparam int PAL_DEPTH      = 1 << INDEX_W;
   localparam int OPCODE_W       = 2;
   localparam int WEIGHT_W       = 9;
   localparam int INV_ADDR_IN_W  = 15;

   localparam int BLEND_RES_LOG  = 8;
   localparam int BLEND_RES      = 1 << BLEND_RES_LOG;
   localparam int CHANNEL_BITS   = 5;

   localparam int INV_AW         = 3 * CHANNEL_BITS;
   localparam int INV_DEPTH      = 1 << INV_AW;

   localparam int SAT_W          = BLEND_RES_LOG + 1;
   localparam int PROD_W         = COLOR_W + SAT_W;
   localparam int SUM_W          = PROD_W + 1;
   localparam int CHAN_LSB       = BLEND_RES_LOG + COLOR_W - CHANNEL_BITS;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(128);

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_PALETTE = 2'd0,
      OP_LOAD_INVERSE = 2'd1,
      OP_BLEND        = 2'd2
   } op_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   // item leaving the blend arithmetic, ready for the inverse lookup
   typedef struct packed {
      op_type              op;
      logic                bypass;
      logic [INDEX_W-1:0]  bypass_index;
      logic [INV_AW-1:0]   inv_addr;
      logic [INDEX_W-1:0]  inv_value;
   } lookup_item_type;

   function automatic logic [SAT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
      logic [SAT_W-1:0] res;
      if (32'(w) > 32'(BLEND_RES)) begin
         res = SAT_W'(BLEND_RES);
      end else begin
         res = SAT_W'(w);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pbl_ram.sv -----
// ----------------------------------------------------------------------------
// pbl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/pbl_blend_pipe.sv -----
// ----------------------------------------------------------------------------
// pbl_blend_pipe
// special-case decode, channel multiplies and inverse address forming
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_blend_pipe (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output      logic                             in_ready,
   input  wire pbl_pkg::op_type                  in_op,
   input  wire logic [pbl_pkg::INDEX_W-1:0]      in_first_index,
   input  wire logic [pbl_pkg::INDEX_W-1:0]      in_second_index,
   input  wire pbl_pkg::color_type               in_first_color,
   input  wire pbl_pkg::color_type               in_second_color,
   input  wire logic [pbl_pkg::INV_AW-1:0]       in_inv_addr,
   input  wire logic [pbl_pkg::INDEX_W-1:0]      in_inv_value,
   input  wire logic [pbl_pkg::WEIGHT_W-1:0]     weight,
   output      logic                             out_valid,
   input  wire logic                             out_ready,
   output      pbl_pkg::lookup_item_type         out_item
);

   import pbl_pkg::*;

   // stage 2: products and bypass decision
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_ready;
   op_type                 s2_op_ff;
   logic                   s2_bypass_ff, s2_bypass_in;
   logic [INDEX_W-1:0]     s2_bypass_index_ff, s2_bypass_index_in;
   logic [INV_AW-1:0]      s2_inv_addr_ff;
   logic [INDEX_W-1:0]     s2_inv_value_ff;
   logic [PROD_W-1:0]      s2_prod_a_ff [3];
   logic [PROD_W-1:0]      s2_prod_b_ff [3];
   logic [PROD_W-1:0]      s2_prod_a_in [3];
   logic [PROD_W-1:0]      s2_prod_b_in [3];

   // stage 3: summed channels packed into the inverse address
   logic                   s3_valid_ff, s3_valid_in;
   logic                   s3_ready;
   lookup_item_type        s3_item_ff, s3_item_in;

   logic [SAT_W-1:0]       w_sat;
   logic [SAT_W-1:0]       w_comp;
   logic [COLOR_W-1:0]     chan_a [3];
   logic [COLOR_W-1:0]     chan_b [3];
   logic                   black_a, black_b;
   logic [SUM_W-1:0]       sum [3];
   logic [CHANNEL_BITS-1:0] chan_q [3];

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;

   always_comb begin
      w_sat  = sat_weight(weight);
      w_comp = SAT_W'(BLEND_RES) - w_sat;
      chan_a[0] = in_first_color.red;
      chan_a[1] = in_first_color.green;
      chan_a[2] = in_first_color.blue;
      chan_b[0] = in_second_color.red;
      chan_b[1] = in_second_color.green;
      chan_b[2] = in_second_color.blue;
      for (int c = 0; c < 3; c++) begin
         s2_prod_a_in[c] = PROD_W'(chan_a[c]) * PROD_W'(w_comp);
         s2_prod_b_in[c] = PROD_W'(chan_b[c]) * PROD_W'(w_sat);
      end
      black_a = (in_first_color == '0);
      black_b = (in_second_color == '0);
      s2_bypass_in       = 1'b1;
      s2_bypass_index_in = in_first_index;
      if ((in_first_index == '0) || (in_first_index == in_second_index) || black_a) begin
         s2_bypass_index_in = in_first_index;
      end else if ((in_second_index == '0) || black_b) begin
         s2_bypass_index_in = in_second_index;
      end else begin
         s2_bypass_in = 1'b0;
      end
      s2_valid_in = s2_ready ? in_valid : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_op_ff           <= in_op;
         s2_bypass_ff       <= s2_bypass_in;
         s2_bypass_index_ff <= s2_bypass_index_in;
         s2_inv_addr_ff     <= in_inv_addr;
         s2_inv_value_ff    <= in_inv_value;
         s2_prod_a_ff       <= s2_prod_a_in;
         s2_prod_b_ff       <= s2_prod_b_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c]    = SUM_W'(s2_prod_a_ff[c]) + SUM_W'(s2_prod_b_ff[c]);
         chan_q[c] = sum[c][CHAN_LSB +: CHANNEL_BITS];
      end
      s3_item_in.op           = s2_op_ff;
      s3_item_in.bypass       = s2_bypass_ff;
      s3_item_in.bypass_index = s2_bypass_index_ff;
      s3_item_in.inv_value    = s2_inv_value_ff;
      // loads keep their own address, blends use blue, green, red
      if (s2_op_ff == OP_LOAD_INVERSE) begin
         s3_item_in.inv_addr = s2_inv_addr_ff;
      end else begin
         s3_item_in.inv_addr = {chan_q[2], chan_q[1], chan_q[0]};
      end
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/palette_blend_lookup.sv -----
// ----------------------------------------------------------------------------
// palette_blend_lookup
// blends two palette colors and maps the mix back to an index
// ----------------------------------------------------------------------------
// Four-stage pipeline that takes one item per clock while rsp_ready is not
// held low and presents the result of a blend item at rsp_*; the rate is set
// by the two registered-read memory stages, the palette read at accept and the
// inverse palette read after the arithmetic, each of which can start a new
// access every cycle. Palette loads write at accept time and give no result,
// inverse loads travel down the pipe and write where blends read, so every
// blend sees exactly the loads accepted before it.
// Stages only stall when the stage ahead is full, so bubbles are squeezed out
// and new items are still taken while a finished result waits at rsp_*.
// Neither memory is cleared after reset: a blend that touches an entry never
// loaded returns an arbitrary index. Write the blend weight only while idle.
`default_nettype none

`include "palette_blend_lookup_defines.svh"

module palette_blend_lookup (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_write_enable,
   input  wire logic [pbl_pkg::WEIGHT_W-1:0]        csr_write_data,
   // request items
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [pbl_pkg::OPCODE_W-1:0]        req_opcode,
   input  wire logic [pbl_pkg::INDEX_W-1:0]         req_first_index,
   input  wire logic [pbl_pkg::INDEX_W-1:0]         req_second_index,
   input  wire logic [pbl_pkg::COLOR_W-1:0]         req_red_in,
   input  wire logic [pbl_pkg::COLOR_W-1:0]         req_green_in,
   input  wire logic [pbl_pkg::COLOR_W-1:0]         req_blue_in,
   input  wire logic [pbl_pkg::INV_ADDR_IN_W-1:0]   req_inverse_address,
   input  wire logic [pbl_pkg::INDEX_W-1:0]         req_inverse_value,
   // response items
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [pbl_pkg::INDEX_W-1:0]         rsp_blended_index
);

   import pbl_pkg::*;

   // blend weight register
   logic [WEIGHT_W-1:0]   weight_ff;

   // stage 1: palette read data plus the item fields
   logic                  accept;
   op_type                req_op;
   color_type             pal_wr_data;
   color_type             color_a, color_b;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ready;
   op_type                s1_op_ff;
   logic [INDEX_W-1:0]    s1_first_ff;
   logic [INDEX_W-1:0]    s1_second_ff;
   logic [INV_AW-1:0]     s1_inv_addr_ff;
   logic [INDEX_W-1:0]    s1_inv_value_ff;

   // stage 3 handoff and the inverse palette
   logic                  s3_valid;
   logic                  s3_ready;
   logic                  s3_advance;
   lookup_item_type       s3_item;
   logic                  inv_wr_en;
   logic                  inv_rd_en;
   logic [INDEX_W-1:0]    inv_rd_data;

   // stage 4: output register
   logic                  s4_valid_ff, s4_valid_in;
   logic                  s4_bypass_ff;
   logic [INDEX_W-1:0]    s4_bypass_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write_enable) begin
         weight_ff <= csr_write_data;
      end
   end

   // stage 1 takes a new item whenever it is empty or moving on
   assign req_ready   = !s1_valid_ff || s1_ready;
   assign accept      = req_valid && req_ready;
   assign req_op      = op_type'(req_opcode);
   assign pal_wr_data = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // palette loads finish at accept; undefined opcodes are dropped here too
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = accept && ((req_op == OP_BLEND) || (req_op == OP_LOAD_INVERSE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff        <= req_op;
         s1_first_ff     <= req_first_index;
         s1_second_ff    <= req_second_index;
         s1_inv_addr_ff  <= INV_AW'(req_inverse_address);
         s1_inv_value_ff <= req_inverse_value;
      end
   end

   // two palette copies so both colors of a pair are read in the same cycle
   pbl_ram #(
      .WIDTH ($bits(color_type)),
      .DEPTH (PAL_DEPTH)
   ) u_palette_a (
      .clock   (clock),
      .wr_en   (accept && (req_op == OP_LOAD_PALETTE)),
      .wr_addr (req_first_index),
      .wr_data (pal_wr_data),
      .rd_en   (accept),
      .rd_addr (req_first_index),
      .rd_data (color_a)
   );

   pbl_ram #(
      .WIDTH ($bits(color_type)),
      .DEPTH (PAL_DEPTH)
   ) u_palette_b (
      .clock   (clock),
      .wr_en   (accept && (req_op == OP_LOAD_PALETTE)),
      .wr_addr (req_first_index),
      .wr_data (pal_wr_data),
      .rd_en   (accept),
      .rd_addr (req_second_index),
      .rd_data (color_b)
   );

   // stages 2 and 3: decode, multiply, sum and pack the lookup address
   pbl_blend_pipe u_blend_pipe (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff),
      .in_ready        (s1_ready),
      .in_op           (s1_op_ff),
      .in_first_index  (s1_first_ff),
      .in_second_index (s1_second_ff),
      .in_first_color  (color_a),
      .in_second_color (color_b),
      .in_inv_addr     (s1_inv_addr_ff),
      .in_inv_value    (s1_inv_value_ff),
      .weight          (weight_ff),
      .out_valid       (s3_valid),
      .out_ready       (s3_ready),
      .out_item        (s3_item)
   );

   // inverse loads write where blends read, keeping item order
   assign s3_ready   = !s4_valid_ff || rsp_ready;
   assign s3_advance = s3_valid && s3_ready;
   assign inv_wr_en  = s3_advance && (s3_item.op == OP_LOAD_INVERSE);
   assign inv_rd_en  = s3_advance && (s3_item.op == OP_BLEND) && !s3_item.bypass;

   pbl_ram #(
      .WIDTH (INDEX_W),
      .DEPTH (INV_DEPTH)
   ) u_inverse (
      .clock   (clock),
      .wr_en   (inv_wr_en),
      .wr_addr (s3_item.inv_addr),
      .wr_data (s3_item.inv_value),
      .rd_en   (inv_rd_en),
      .rd_addr (s3_item.inv_addr),
      .rd_data (inv_rd_data)
   );

   // only blends reach the output register
   always_comb begin
      s4_valid_in = s4_valid_ff;
      if (s3_ready) begin
         s4_valid_in = s3_valid && (s3_item.op == OP_BLEND);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_advance) begin
         s4_bypass_ff       <= s3_item.bypass;
         s4_bypass_index_ff <= s3_item.bypass_index;
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_blended_index = s4_bypass_ff ? s4_bypass_index_ff : inv_rd_data;

   // checks
   `PBL_ASSERT_NOW(a_inv_port_exclusive, clock, reset,
      inv_wr_en, !inv_rd_en,
      "inverse palette read and written in one cycle")
   `PBL_ASSERT_NEXT(a_blend_enters_pipe, clock, reset,
      accept && (req_op == OP_BLEND), s1_valid_ff,
      "accepted blend item not held in stage 1")
   `PBL_ASSERT_NEXT(a_stage1_holds, clock, reset,
      s1_valid_ff && !s1_ready, s1_valid_ff && $stable(s1_first_ff),
      "stalled stage 1 item lost or changed")
   `PBL_ASSERT_NOW(a_drop_only_blends, clock, reset,
      s3_advance && (s3_item.op != OP_BLEND), s3_item.op == OP_LOAD_INVERSE,
      "unexpected item kind leaving stage 3")

endmodule

`default_nettype wire
